### sv/adsr_pkg.sv
package adsr_pkg;

  // Envelope phase, as reported on the result stream
  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // Request kind carried on the input tuser
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_SCALE    = 2'd3
  } req_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  localparam int NOTE_W   = 7;
  localparam int SAMPLE_W = 8;
  localparam int PHASE_W  = 3;

endpackage

### sv/adsr_step.sv
// Next-state and result logic for one envelope item. Purely combinational:
// it sits between the input register and the state and result registers.
module adsr_step
  import adsr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  req_t                  req,
  input  logic [NOTE_W-1:0]     note,
  input  logic [FRAC_BITS:0]    vel,
  input  logic [SAMPLE_W-1:0]   sample,
  input  phase_t                phase,
  input  logic [FRAC_BITS:0]    level,
  input  logic [NOTE_W-1:0]     held_note,
  input  logic [FRAC_BITS:0]    peak_vel,
  input  logic [FRAC_BITS:0]    attack_rate,
  input  logic [FRAC_BITS:0]    decay_rate,
  input  logic [FRAC_BITS:0]    sustain_fraction,
  input  logic [FRAC_BITS:0]    release_rate,
  output phase_t                phase_next,
  output logic [FRAC_BITS:0]    level_next,
  output logic [NOTE_W-1:0]     held_note_next,
  output logic [FRAC_BITS:0]    peak_vel_next,
  output logic [SAMPLE_W-1:0]   scaled
);

  localparam int LW = FRAC_BITS + 1;
  localparam int PW = 2 * LW;
  localparam int SW = SAMPLE_W + LW;

  logic [LW-1:0] rate_sel;
  logic [PW-1:0] rate_prod;
  logic [PW-1:0] sus_prod;
  logic [LW-1:0] p;
  logic [LW-1:0] s;
  logic [LW:0]   att_sum;
  logic [LW:0]   sus_plus_p;
  logic          att_done;
  logic          dec_done;
  logic          rel_done;
  logic [SW-1:0] scale_prod;
  logic [SW-FRAC_BITS-1:0] scale_shr;

  // Only one step rate applies in any phase, so one multiplier serves them all
  always_comb begin
    case (phase)
      PH_ATTACK: rate_sel = attack_rate;
      PH_DECAY:  rate_sel = decay_rate;
      default:   rate_sel = release_rate;
    endcase
  end

  // Rate and sustain products, truncated back to the level format
  assign rate_prod = PW'(rate_sel) * PW'(peak_vel);
  assign sus_prod  = PW'(sustain_fraction) * PW'(peak_vel);
  assign p = rate_prod[FRAC_BITS +: LW];
  assign s = sus_prod[FRAC_BITS +: LW];

  // Target compares for each moving phase
  assign att_sum    = {1'b0, level} + {1'b0, p};
  assign sus_plus_p = {1'b0, s} + {1'b0, p};
  assign att_done   = att_sum >= {1'b0, peak_vel};
  assign dec_done   = {1'b0, level} <= sus_plus_p;
  assign rel_done   = level <= p;

  // Phase transitions
  always_comb begin
    phase_next = phase;
    unique case (req)
      REQ_TICK: begin
        unique case (phase)
          PH_ATTACK:  if (att_done) phase_next = PH_DECAY;
          PH_DECAY:   if (dec_done) phase_next = PH_SUSTAIN;
          PH_RELEASE: if (rel_done) phase_next = PH_OFF;
          PH_OFF, PH_SUSTAIN: phase_next = phase;
          default: phase_next = phase;
        endcase
      end
      REQ_NOTE_ON:  phase_next = PH_ATTACK;
      REQ_NOTE_OFF: if (note == held_note) phase_next = PH_RELEASE;
      REQ_SCALE:    phase_next = phase;
      default:      phase_next = phase;
    endcase
  end

  // Level, held note, velocity and the scaled sample
  assign scale_prod = SW'(sample) * SW'(level);
  assign scale_shr  = scale_prod[SW-1:FRAC_BITS];

  always_comb begin
    level_next     = level;
    held_note_next = held_note;
    peak_vel_next  = peak_vel;
    scaled         = '0;
    unique case (req)
      REQ_TICK: begin
        unique case (phase)
          PH_OFF:     level_next = '0;
          PH_ATTACK:  level_next = att_done ? peak_vel : att_sum[LW-1:0];
          PH_DECAY:   level_next = dec_done ? s : level - p;
          PH_SUSTAIN: level_next = s;
          PH_RELEASE: level_next = rel_done ? '0 : level - p;
          default:    level_next = level;
        endcase
      end
      REQ_NOTE_ON: begin
        held_note_next = note;
        peak_vel_next  = vel;
      end
      REQ_NOTE_OFF: level_next = level;
      REQ_SCALE: begin
        // Cap the shifted product at the largest sample value
        if (scale_shr > (SW-FRAC_BITS)'(2**SAMPLE_W - 1)) begin
          scaled = '1;
        end else begin
          scaled = scale_shr[SAMPLE_W-1:0];
        end
      end
      default: level_next = level;
    endcase
  end

endmodule

### sv/adsr_envelope_generator_top.sv
// Channel   Direction  Transfer on             Contents
// s_axis    in         s_tvalid & s_tready     tuser: req_type; tdata: note, velocity, sample
// m_axis    out        m_tvalid & m_tready     tdata: level, phase, scaled sample
// cfg       in         cfg_wr_en high          cfg_index selects the rate register
//
// One item per cycle sustained while m_tready is high. An item waits in the input
// register, then the step logic updates the envelope state and loads the
// result register once that register is free.
// Reset clears the envelope to off and loads the default rates.
// A stalled result holds; one further item can still be taken meanwhile.
module adsr_envelope_generator_top
  import adsr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // Input stream
  input  logic s_tvalid,
  output logic s_tready,
  // tdata from bit 0: note_number, note_velocity, wave_sample
  input  logic [((NOTE_W+FRAC_BITS+1+SAMPLE_W+7)/8)*8-1:0] s_tdata,
  // tuser: req_type
  input  logic [1:0] s_tuser,
  // Result stream
  output logic m_tvalid,
  input  logic m_tready,
  // tdata from bit 0: env_level, env_phase, scaled_sample
  output logic [((FRAC_BITS+1+PHASE_W+SAMPLE_W+7)/8)*8-1:0] m_tdata,
  // Configuration writes
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [FRAC_BITS:0]  cfg_wdata
);

  localparam int LW      = FRAC_BITS + 1;
  localparam int OUT_RAW = LW + PHASE_W + SAMPLE_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam logic [LW-1:0] ONE         = LW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] DECAY_RST   = LW'((64'd1311 << FRAC_BITS) >> 16);
  localparam logic [LW-1:0] SUSTAIN_RST = LW'((64'd3277 << FRAC_BITS) >> 16);
  localparam logic [LW-1:0] RELEASE_RST = LW'((64'd6554 << FRAC_BITS) >> 16);

  // Configuration registers
  logic [LW-1:0] attack_rate;
  logic [LW-1:0] decay_rate;
  logic [LW-1:0] sustain_fraction;
  logic [LW-1:0] release_rate;
  logic [LW-1:0] cfg_sat;

  // Envelope state
  phase_t            phase;
  logic [LW-1:0]     level;
  logic [NOTE_W-1:0] held_note;
  logic [LW-1:0]     peak_vel;

  // Input register
  logic                in_valid;
  req_t                in_req;
  logic [NOTE_W-1:0]   in_note;
  logic [LW-1:0]       in_vel;
  logic [SAMPLE_W-1:0] in_sample;

  // Result register
  logic                out_valid;
  logic [OUT_RAW-1:0]  out_data;

  // Step logic outputs
  phase_t              phase_next;
  logic [LW-1:0]       level_next;
  logic [NOTE_W-1:0]   held_note_next;
  logic [LW-1:0]       peak_vel_next;
  logic [SAMPLE_W-1:0] scaled;

  logic out_free;
  logic advance;
  logic [LW-1:0] vel_raw;

  // Flow control: the item moves on when the result register is free
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Register values above one are taken as one
  assign cfg_sat = (cfg_wdata > ONE) ? ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_rate      <= ONE;
      decay_rate       <= DECAY_RST;
      sustain_fraction <= SUSTAIN_RST;
      release_rate     <= RELEASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_rate      <= cfg_sat;
        CFG_DECAY:   decay_rate       <= cfg_sat;
        CFG_SUSTAIN: sustain_fraction <= cfg_sat;
        CFG_RELEASE: release_rate     <= cfg_sat;
        default:     attack_rate      <= attack_rate;
      endcase
    end
  end

  // Input register, velocity clamped to one on the way in
  assign vel_raw = s_tdata[NOTE_W +: LW];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= req_t'(s_tuser);
      in_note   <= s_tdata[NOTE_W-1:0];
      in_vel    <= (vel_raw > ONE) ? ONE : vel_raw;
      in_sample <= s_tdata[NOTE_W+LW +: SAMPLE_W];
    end
  end

  adsr_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .req              (in_req),
    .note             (in_note),
    .vel              (in_vel),
    .sample           (in_sample),
    .phase            (phase),
    .level            (level),
    .held_note        (held_note),
    .peak_vel         (peak_vel),
    .attack_rate      (attack_rate),
    .decay_rate       (decay_rate),
    .sustain_fraction (sustain_fraction),
    .release_rate     (release_rate),
    .phase_next       (phase_next),
    .level_next       (level_next),
    .held_note_next   (held_note_next),
    .peak_vel_next    (peak_vel_next),
    .scaled           (scaled)
  );

  // Envelope state updates as each item passes the step logic
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OFF;
      level     <= '0;
      held_note <= '0;
      peak_vel  <= ONE;
    end else if (advance) begin
      phase     <= phase_next;
      level     <= level_next;
      held_note <= held_note_next;
      peak_vel  <= peak_vel_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {scaled, PHASE_W'(phase_next), level_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule

### verif/adsr_envelope_generator_checker.sv
`timescale 1ns / 1ps

module adsr_envelope_generator_checker
  import adsr_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int IN_W      = ((NOTE_W + FRAC_BITS + 1 + SAMPLE_W + 7) / 8) * 8,
  parameter int OUT_W     = ((FRAC_BITS + 1 + PHASE_W + SAMPLE_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // tdata from bit 0: note_number, note_velocity, wave_sample
  input  logic [IN_W-1:0]      s_tdata,
  // tuser: req_type
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // tdata from bit 0: env_level, env_phase, scaled_sample
  input  logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [FRAC_BITS:0]   cfg_wdata,
  output int                   fail_count,
  output int                   results_checked,
  output int                   outstanding
);

  localparam int LVL_W = FRAC_BITS + 1;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] scaled;
    phase_t              phase;
    level_t              level;
  } env_result_t;

  localparam level_t FULL_SCALE = {1'b1, {FRAC_BITS{1'b0}}};

  // Envelope state and rate registers as the block should hold them
  phase_t            env_phase;
  level_t            env_level;
  logic [NOTE_W-1:0] held_note;
  level_t            peak_vel;
  level_t            attack_r;
  level_t            decay_r;
  level_t            sustain_f;
  level_t            release_r;

  env_result_t       envelope_q[$];
  env_result_t       next_res;
  env_result_t       want;
  level_t            got_level;
  logic [PHASE_W-1:0]  got_phase;
  logic [SAMPLE_W-1:0] got_scaled;

  // Values above full scale are taken as full scale.
  function automatic level_t clamp_full(input level_t v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  // Truncated fraction of the note velocity.
  function automatic level_t rate_share(input level_t rate, input level_t vel);
    logic [2*LVL_W-1:0] prod;
    prod = rate * vel;
    return level_t'(prod >> FRAC_BITS);
  endfunction

  // Apply one request to the envelope state and work out its result.
  task automatic step_envelope(input req_t req, input logic [NOTE_W-1:0] note,
                               input level_t vel, input logic [SAMPLE_W-1:0] sample,
                               output env_result_t res);
    logic [LVL_W:0]            wide;
    level_t                    share;
    level_t                    sus_level;
    logic [SAMPLE_W+LVL_W-1:0] prod;
    logic [SAMPLE_W+LVL_W-1:0] shifted;
    res.scaled = '0;
    sus_level = rate_share(sustain_f, peak_vel);
    case (req)
      REQ_TICK: begin
        case (env_phase)
          PH_OFF: env_level = '0;
          PH_ATTACK: begin
            wide = env_level + rate_share(attack_r, peak_vel);
            if (wide >= peak_vel) begin
              env_level = peak_vel;
              env_phase = PH_DECAY;
            end else begin
              env_level = wide[LVL_W-1:0];
            end
          end
          PH_DECAY: begin
            share = rate_share(decay_r, peak_vel);
            wide  = sus_level + share;
            // A step that would cross below the sustain level lands on it.
            if (env_level <= wide) begin
              env_level = sus_level;
              env_phase = PH_SUSTAIN;
            end else begin
              env_level = env_level - share;
            end
          end
          PH_SUSTAIN: env_level = sus_level;
          PH_RELEASE: begin
            share = rate_share(release_r, peak_vel);
            if (env_level <= share) begin
              env_level = '0;
              env_phase = PH_OFF;
            end else begin
              env_level = env_level - share;
            end
          end
          default: ;
        endcase
      end
      REQ_NOTE_ON: begin
        // The level is kept; only the phase restarts.
        held_note = note;
        peak_vel  = clamp_full(vel);
        env_phase = PH_ATTACK;
      end
      REQ_NOTE_OFF: begin
        if (note == held_note) env_phase = PH_RELEASE;
      end
      default: begin
        prod    = sample * env_level;
        shifted = prod >> FRAC_BITS;
        res.scaled = (shifted > 255) ? SAMPLE_W'(255) : shifted[SAMPLE_W-1:0];
      end
    endcase
    res.level = env_level;
    res.phase = env_phase;
  endtask

  // Follow configuration writes, input transfers and result transfers.
  always @(posedge clk) begin
    if (rst) begin
      env_phase = PH_OFF;
      env_level = '0;
      held_note = '0;
      peak_vel  = FULL_SCALE;
      attack_r  = FULL_SCALE;
      decay_r   = level_t'(1311);
      sustain_f = level_t'(3277);
      release_r = level_t'(6554);
      envelope_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ATTACK:  attack_r  = clamp_full(cfg_wdata);
          CFG_DECAY:   decay_r   = clamp_full(cfg_wdata);
          CFG_SUSTAIN: sustain_f = clamp_full(cfg_wdata);
          CFG_RELEASE: release_r = clamp_full(cfg_wdata);
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        step_envelope(req_t'(s_tuser), s_tdata[NOTE_W-1:0], s_tdata[NOTE_W +: LVL_W],
                      s_tdata[NOTE_W+LVL_W +: SAMPLE_W], next_res);
        envelope_q.push_back(next_res);
      end

      if (m_tvalid && m_tready) begin
        got_level  = m_tdata[0 +: LVL_W];
        got_phase  = m_tdata[LVL_W +: PHASE_W];
        got_scaled = m_tdata[LVL_W+PHASE_W +: SAMPLE_W];
        if (envelope_q.size() == 0) begin
          $error("result transfer with nothing expected: level %0d phase %0d scaled %0d",
                 got_level, got_phase, got_scaled);
          fail_count++;
        end else begin
          want = envelope_q.pop_front();
          results_checked++;
          if (got_level !== want.level) begin
            $error("env_level mismatch: expected %0d, actual %0d", want.level, got_level);
            fail_count++;
          end
          if (got_phase !== want.phase) begin
            $error("env_phase mismatch: expected %0d, actual %0d", want.phase, got_phase);
            fail_count++;
          end
          if (got_scaled !== want.scaled) begin
            $error("scaled_sample mismatch: expected %0d, actual %0d", want.scaled,
                   got_scaled);
            fail_count++;
          end
        end
      end
    end
    outstanding = envelope_q.size();
  end

endmodule

### verif/adsr_envelope_generator_top_test.sv
`timescale 1ns / 1ps

module adsr_envelope_generator_top_test;
  import adsr_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int LVL_W       = FRAC_BITS + 1;
  localparam int IN_W        = ((NOTE_W + LVL_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W       = ((LVL_W + PHASE_W + SAMPLE_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 105;
  localparam logic [LVL_W-1:0] FULL_SCALE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] ALL_ONES   = {LVL_W{1'b1}};

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [FRAC_BITS:0]  cfg_wdata;

  int fail_count;
  int results_checked;
  int outstanding;
  int cycle_count;
  int kind_count[4];
  int settings_applied;
  int hold_asked;
  int hold_taken;
  int hold_left;
  bit steady;
  logic [NOTE_W-1:0] last_note;

  adsr_envelope_generator_top #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  adsr_envelope_generator_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .outstanding     (outstanding)
  );

  // Clock generation
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the overall run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = LONG_HOLD - 1;
        m_tready  = 1'b0;
      end else begin
        m_tready = steady || ($urandom_range(99) >= 26);
      end
    end
  end

  // Offer one request and wait for its transfer; returns at a falling edge.
  task automatic send_item(input req_t req, input logic [NOTE_W-1:0] note,
                           input logic [LVL_W-1:0] vel, input logic [SAMPLE_W-1:0] sample);
    while (!steady && $urandom_range(99) < 26) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = IN_W'({sample, vel, note});
    do @(posedge clk); while (!s_tready);
    kind_count[req]++;
    if (req == REQ_NOTE_ON) last_note = note;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Load all four rate registers while the block is idle.
  task automatic program_rates(input logic [LVL_W-1:0] atk, input logic [LVL_W-1:0] dec,
                               input logic [LVL_W-1:0] sus, input logic [LVL_W-1:0] rel);
    logic [1:0]       idx[4];
    logic [LVL_W-1:0] val[4];
    idx = '{CFG_ATTACK, CFG_DECAY, CFG_SUSTAIN, CFG_RELEASE};
    val = '{atk, dec, sus, rel};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en = 1'b1;
      cfg_index = idx[i];
      cfg_wdata = val[i];
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
    settings_applied++;
  endtask

  function automatic logic [LVL_W-1:0] pick_velocity();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 16) return FULL_SCALE;
    if (r < 26) return LVL_W'($urandom_range(FULL_SCALE + 1, ALL_ONES));
    return LVL_W'($urandom_range(1, FULL_SCALE));
  endfunction

  // Mostly ticks and samples around note-on/note-off pairs, some stray note-offs.
  task automatic random_items(input int count);
    int   r;
    req_t req;
    logic [NOTE_W-1:0] note;
    for (int i = 0; i < count; i++) begin
      r    = $urandom_range(99);
      note = NOTE_W'($urandom_range(0, 127));
      if (r < 52) req = REQ_TICK;
      else if (r < 70) req = REQ_SCALE;
      else if (r < 80) req = REQ_NOTE_ON;
      else begin
        req = REQ_NOTE_OFF;
        if ($urandom_range(99) < 70) note = last_note;
      end
      send_item(req, note, pick_velocity(), SAMPLE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_TICK;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ATTACK;
    cfg_wdata = '0;
    steady    = 1'b0;
    last_note = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset rates
    send_item(REQ_SCALE,    7'd0,   '0,         8'd255);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    // Matching note-off while off, then release straight back to off
    send_item(REQ_NOTE_OFF, 7'd0,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    // Over-range velocity is stored as full scale
    send_item(REQ_NOTE_ON,  7'd127, ALL_ONES,   8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_SCALE,    7'd0,   '0,         8'd255);
    send_item(REQ_SCALE,    7'd0,   '0,         8'd0);
    send_item(REQ_SCALE,    7'd0,   '0,         8'd128);
    send_item(REQ_NOTE_OFF, 7'd5,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    // Note-on during decay keeps the level
    send_item(REQ_NOTE_ON,  7'd127, FULL_SCALE, 8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_NOTE_OFF, 7'd127, '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_NOTE_OFF, 7'd127, '0,         8'd0);
    send_item(REQ_SCALE,    7'd0,   '0,         8'd170);
    // Zero velocity runs through attack and decay at once
    send_item(REQ_NOTE_ON,  7'd0,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_SCALE,    7'd0,   '0,         8'd200);
    send_item(REQ_NOTE_ON,  7'd64,  17'd32768,  8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);
    send_item(REQ_TICK,     7'd0,   '0,         8'd0);

    // Slowest rates and zero sustain, with a long result hold-off
    program_rates(17'd256, 17'd256, 17'd0, 17'd256);
    hold_asked++;
    random_items(PHASE_ITEMS);

    // Full-scale rates, streamed with no idle cycles on either side
    program_rates(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
    steady = 1'b1;
    random_items(PHASE_ITEMS);
    steady = 1'b0;

    // Over-range register values
    program_rates(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    random_items(PHASE_ITEMS);

    // Random settings inside the legal range
    repeat (3) begin
      program_rates(LVL_W'($urandom_range(2048, FULL_SCALE)),
                    LVL_W'($urandom_range(2048, FULL_SCALE)),
                    LVL_W'($urandom_range(0, FULL_SCALE)),
                    LVL_W'($urandom_range(2048, FULL_SCALE)));
      random_items(PHASE_ITEMS);
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d ticks, %0d note-ons, %0d note-offs and %0d scale requests;",
             kind_count[REQ_TICK], kind_count[REQ_NOTE_ON], kind_count[REQ_NOTE_OFF],
             kind_count[REQ_SCALE]);
    $display("%0d results checked over %0d rate settings beyond reset, from floor to over-range.",
             results_checked, settings_applied);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
